@@ hdl/srsg_pkg.sv @@
package srsg_pkg;

	localparam int VEL_W   = 31;
	localparam int THR_W   = 16;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 31;
	localparam int REG_IDX_W = 3;

	localparam logic [THR_W-1:0] PULSE_THR_RST = 16'd20000;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_JOG  = 2'd1,
		KIND_MOVE = 2'd2
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACCEL      = 3'd0,
		REG_PULSE_THR  = 3'd1,
		REG_BACKLASH   = 3'd2,
		REG_INVERT_DIR = 3'd3,
		REG_USE_LIMITS = 3'd4,
		REG_LIMIT_POL  = 3'd5,
		REG_ESTOP_POL  = 3'd6
	} reg_idx_t;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_ESTOP = 2'd1;
	localparam logic [1:0] ERR_LIMIT = 2'd2;

	typedef struct packed {
		logic [VEL_W-1:0] accel;
		logic [THR_W-1:0] pulse_thr;
		logic [THR_W-1:0] backlash;
		logic             invert_dir;
		logic             use_limits;
		logic             limit_pol;
		logic             estop_pol;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             estop_raw;
		logic             limit_raw;
		logic             direction_cmd;
		logic [VEL_W-1:0] velocity_value;
		logic [VEL_W-1:0] move_steps;
	} item_t;

	typedef struct packed {
		logic [VEL_W-1:0] velocity;
		logic [VEL_W-1:0] target_velocity;
		logic [THR_W-1:0] accumulator;
		logic             decelerating;
		logic             up_to_speed;
		logic             axis_active;
		logic             busy_flag;
		logic             motor_direction;
		logic [THR_W-1:0] backlash_remaining;
		logic [CNT_W-1:0] steps_remaining;
		logic [CNT_W-1:0] steps_to_speed;
		logic [CNT_W-1:0] position_count;
	} axis_state_t;

	typedef struct packed {
		logic                    step_pulse;
		logic                    motor_dir;
		logic signed [CNT_W-1:0] position;
		logic                    moving;
		logic                    move_busy;
		logic [1:0]              error;
	} result_t;

endpackage

@@ hdl/srsg_ifs.sv @@
interface srsg_cmd_if;
	import srsg_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic             estop_raw;
	logic             limit_raw;
	logic             direction_cmd;
	logic [VEL_W-1:0] velocity_value;
	logic [VEL_W-1:0] move_steps;

	modport source (output valid, kind, estop_raw, limit_raw, direction_cmd,
		velocity_value, move_steps, input ready);
	modport sink (input valid, kind, estop_raw, limit_raw, direction_cmd,
		velocity_value, move_steps, output ready);
endinterface

interface srsg_rsp_if;
	import srsg_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    step_pulse;
	logic                    motor_dir;
	logic signed [CNT_W-1:0] position;
	logic                    moving;
	logic                    move_busy;
	logic [1:0]              error;

	modport source (output valid, step_pulse, motor_dir, position, moving, move_busy,
		error, input ready);
	modport sink (input valid, step_pulse, motor_dir, position, moving, move_busy,
		error, output ready);
endinterface

@@ hdl/stepper_ramp_step_generator.sv @@
// Single-axis stepper pulse generator with a trapezoidal velocity ramp.
//
// Channels: cmd carries one command per transfer (tick, jog target, or
// distance move start) together with the sampled emergency stop and limit
// levels; rsp returns exactly one status item per command: the step pulse
// for that tick, the direction pin, the signed position, the moving and
// move-busy flags, and an error code. Registers are written through the
// cfg_we / cfg_index / cfg_data port by the user, only while no command
// is in flight; the block does not enforce this.
// A transferred command is held in the input stage and evaluated against
// the axis state; its status is captured in the status register, which
// drives rsp. Throughput is one command per cycle while rsp does not stall;
// the evaluation is a single pass of ramp add, accumulator add and
// counter updates between the input stage and the status register.
//
// When the receiver stalls, the status register holds its item and the input
// stage still takes one more command, so cmd.ready falls only when both are
// full. Reset clears all motion state and loads the register defaults
// (pulse threshold 20000, everything else zero).
module stepper_ramp_step_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	srsg_cmd_if.sink                       cmd,
	srsg_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [srsg_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [srsg_pkg::CFG_W-1:0]     cfg_data
);
	import srsg_pkg::*;

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	axis_state_t state_q;
	axis_state_t state_nxt;
	result_t     result;
	result_t     rsp_q;
	logic        rsp_valid_q;
	logic        out_free;
	logic        advance;

	srsg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// The status register is free when empty or when its item is leaving now.
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Command payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.kind           <= cmd.kind;
			item_s1.estop_raw      <= cmd.estop_raw;
			item_s1.limit_raw      <= cmd.limit_raw;
			item_s1.direction_cmd  <= cmd.direction_cmd;
			item_s1.velocity_value <= cmd.velocity_value;
			item_s1.move_steps     <= cmd.move_steps;
		end
	end

	srsg_step_logic u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (result)
	);

	// Axis state advances exactly once per command, when its status is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.step_pulse = rsp_q.step_pulse;
	assign rsp.motor_dir  = rsp_q.motor_dir;
	assign rsp.position   = rsp_q.position;
	assign rsp.moving     = rsp_q.moving;
	assign rsp.move_busy  = rsp_q.move_busy;
	assign rsp.error      = rsp_q.error;
endmodule

@@ hdl/srsg_cfg_regs.sv @@
module srsg_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [srsg_pkg::REG_IDX_W-1:0]     index,
	input  logic [srsg_pkg::CFG_W-1:0]         data,
	output srsg_pkg::cfg_t                     cfg
);
	import srsg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{accel: '0, pulse_thr: PULSE_THR_RST, backlash: '0,
				invert_dir: 1'b0, use_limits: 1'b0, limit_pol: 1'b0, estop_pol: 1'b0};
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_ACCEL:      cfg_q.accel      <= data[VEL_W-1:0];
				REG_PULSE_THR:  cfg_q.pulse_thr  <= data[THR_W-1:0];
				REG_BACKLASH:   cfg_q.backlash   <= data[THR_W-1:0];
				REG_INVERT_DIR: cfg_q.invert_dir <= data[0];
				REG_USE_LIMITS: cfg_q.use_limits <= data[0];
				REG_LIMIT_POL:  cfg_q.limit_pol  <= data[0];
				REG_ESTOP_POL:  cfg_q.estop_pol  <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ hdl/srsg_step_logic.sv @@
module srsg_step_logic (
	input  srsg_pkg::cfg_t        cfg,
	input  srsg_pkg::item_t       item,
	input  srsg_pkg::axis_state_t cur,
	output srsg_pkg::axis_state_t nxt,
	output srsg_pkg::result_t     res
);
	import srsg_pkg::*;

	logic [CNT_W-1:0] vel_dn;
	logic [CNT_W-1:0] vel_up;
	logic [CNT_W-1:0] rem_prev;
	logic             new_dir;
	logic             step;
	logic [1:0]       err;

	always_comb begin
		nxt      = cur;
		step     = 1'b0;
		err      = ERR_NONE;
		new_dir  = item.direction_cmd ^ cfg.invert_dir;
		rem_prev = '0;
		vel_dn   = {1'b0, cur.velocity} - {1'b0, cfg.accel};
		vel_up   = {1'b0, cur.velocity} + {1'b0, cfg.accel};

		case (item.kind)
			KIND_TICK: begin
				if (item.estop_raw ^ cfg.estop_pol) begin
					nxt.velocity        = '0;
					nxt.target_velocity = '0;
					nxt.axis_active     = 1'b0;
					nxt.busy_flag       = 1'b0;
					err                 = ERR_ESTOP;
				end else if (cur.axis_active) begin
					// Ramp the velocity first; a negative difference counts as below target.
					if (cur.decelerating) begin
						if (vel_dn[CNT_W-1] || (vel_dn[VEL_W-1:0] < cur.target_velocity)) begin
							nxt.decelerating = 1'b0;
							nxt.velocity     = cur.target_velocity;
							if (cur.target_velocity == '0) begin
								nxt.axis_active = 1'b0;
								nxt.busy_flag   = 1'b0;
							end
						end else begin
							nxt.velocity = vel_dn[VEL_W-1:0];
						end
					end else if (vel_up <= {1'b0, cur.target_velocity}) begin
						nxt.velocity = vel_up[VEL_W-1:0];
					end else begin
						nxt.velocity    = cur.target_velocity;
						nxt.up_to_speed = 1'b1;
					end

					nxt.accumulator = nxt.accumulator +
						{1'b0, nxt.velocity[VEL_W-1:THR_W]};

					if (nxt.accumulator >= cfg.pulse_thr) begin
						step = 1'b1;
						if (new_dir != cur.motor_direction) begin
							nxt.backlash_remaining = cfg.backlash;
							nxt.steps_remaining    = nxt.steps_remaining +
								{{(CNT_W-THR_W){1'b0}}, cfg.backlash};
						end
						nxt.motor_direction = new_dir;
						nxt.accumulator     = nxt.accumulator - cfg.pulse_thr;

						if (nxt.backlash_remaining == '0) begin
							nxt.position_count = item.direction_cmd ?
								nxt.position_count + 1'b1 : nxt.position_count - 1'b1;
						end else begin
							nxt.backlash_remaining = nxt.backlash_remaining - 1'b1;
						end

						if (nxt.busy_flag) begin
							if (cfg.use_limits && (item.limit_raw ^ cfg.limit_pol)) begin
								nxt.steps_remaining = '0;
								nxt.busy_flag       = 1'b0;
								err                 = ERR_LIMIT;
							end
							rem_prev            = nxt.steps_remaining;
							nxt.steps_remaining = nxt.steps_remaining - 1'b1;
							if ($signed(rem_prev) <= $signed(nxt.steps_to_speed)) begin
								// Distance left is no more than the ramp-up distance: start braking.
								nxt.steps_to_speed  = '1;
								nxt.target_velocity = '0;
								nxt.decelerating    = 1'b1;
								nxt.up_to_speed     = 1'b1;
							end else if ($signed(nxt.steps_remaining) <= $signed(CNT_W'(0))) begin
								nxt.velocity        = '0;
								nxt.target_velocity = '0;
								nxt.accumulator     = '0;
								nxt.busy_flag       = 1'b0;
							end
						end

						if (!nxt.up_to_speed) begin
							nxt.steps_to_speed = nxt.steps_to_speed + 1'b1;
						end
					end
				end
			end
			KIND_JOG: begin
				nxt.target_velocity = item.velocity_value;
				nxt.axis_active     = 1'b1;
				nxt.decelerating    = item.velocity_value < cur.velocity;
			end
			KIND_MOVE: begin
				nxt.target_velocity = item.velocity_value;
				nxt.steps_remaining = {1'b0, item.move_steps};
				nxt.busy_flag       = 1'b1;
				nxt.axis_active     = 1'b1;
				nxt.decelerating    = 1'b0;
				nxt.up_to_speed     = 1'b0;
				nxt.steps_to_speed  = '0;
			end
			default: ;
		endcase

		res.step_pulse = step;
		res.motor_dir  = nxt.motor_direction;
		res.position   = $signed(nxt.position_count);
		res.moving     = nxt.axis_active;
		res.move_busy  = nxt.busy_flag;
		res.error      = err;
	end
endmodule

@@ hdl/srsg_checker.sv @@
module srsg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_step_pulse,
	input logic                           rsp_moving,
	input logic                           rsp_move_busy,
	input logic [1:0]                     rsp_error,
	input logic signed [srsg_pkg::CNT_W-1:0] rsp_position
);
	import srsg_pkg::*;

	// A stalled status item stays valid and keeps its position and error.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_error))
		else $error("status item changed while stalled");

	// A limit abort only happens on a step and always ends the move.
	a_limit_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_error == ERR_LIMIT |-> rsp_step_pulse && !rsp_move_busy)
		else $error("limit abort without step or with move still busy");

	// Emergency stop leaves the axis fully at rest.
	a_estop_rest: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_error == ERR_ESTOP |-> !rsp_step_pulse && !rsp_moving && !rsp_move_busy)
		else $error("motion reported during emergency stop");

	// A distance move in progress implies the axis is active.
	a_busy_moving: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_move_busy |-> rsp_moving)
		else $error("move busy while axis inactive");
endmodule

bind stepper_ramp_step_generator srsg_checker u_srsg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_step_pulse (rsp.step_pulse),
	.rsp_moving     (rsp.moving),
	.rsp_move_busy  (rsp.move_busy),
	.rsp_error      (rsp.error),
	.rsp_position   (rsp.position)
);
